[design/thc_pkg.sv]
// Shared types, constants and helper functions for the thermistor converter.
// Used by every module in the design folder; no dependencies.
package thc_pkg;

    localparam int ADC_BITS   = 10;
    localparam int ADC_FULL   = (1 << ADC_BITS) - 1;
    localparam int SER_W      = 20;
    localparam int COEF_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TEMP_W     = 10;

    localparam int X_W      = SER_W + ADC_BITS;
    localparam int LOG_FRAC = 30;
    localparam int N_W      = $clog2(X_W);
    localparam int R_W      = N_W + LOG_FRAC;
    localparam int Y_W      = LOG_FRAC + 1;
    localparam int S_W      = 44;
    localparam int DIV_W    = 57;
    localparam int Q_W      = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES = 3'd3;

    localparam logic [COEF_W-1:0] COEF_A_RST = 32'd1273465600;
    localparam logic [COEF_W-1:0] COEF_B_RST = 32'd247660837;
    localparam logic [COEF_W-1:0] COEF_C_RST = 32'd931381;
    localparam logic [SER_W-1:0]  SERIES_RST = 20'd10000;

    localparam logic [28:0] LN2_Q28 = 29'd186065279;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -10'sd100;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 10'sd400;

    typedef enum logic [1:0] {
        CLS_NORM,
        CLS_HOT,
        CLS_COLD
    } thc_cls_t;

    typedef struct packed {
        logic [Y_W-1:0] y1;
        logic [Y_W-1:0] y2;
        logic [R_W-1:0] r1;
        logic [R_W-1:0] r2;
        logic           ok;
    } thc_log_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dsh;
        logic [Q_W-1:0]   q;
        logic             neg;
        logic             ovf;
        thc_cls_t         cls;
        logic             ok;
    } thc_div_t;

    function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                     input int s);
        logic [63:0] mag;
        logic [63:0] rnd;
        mag = v[63] ? 64'(-v) : 64'(v);
        rnd = (mag + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(rnd) : $signed(rnd);
    endfunction

    function automatic logic [N_W-1:0] msb_pos(input logic [X_W-1:0] x);
        logic [N_W-1:0] p;
        p = '0;
        for (int i = 0; i < X_W; i++) begin
            if (x[i])
                p = N_W'(i);
        end
        return p;
    endfunction

    function automatic logic [Y_W-1:0] norm_mant(input logic [X_W-1:0] x,
                                                 input logic [N_W-1:0] n);
        logic [X_W+LOG_FRAC-1:0] w;
        w = {x, {LOG_FRAC{1'b0}}} >> n;
        return w[Y_W-1:0];
    endfunction

endpackage

[design/thermistor_adc_to_celsius_top.sv]
// Thermistor ADC code to whole degrees Celsius, three-term form A + B*lnR + C*lnR^2.
// Depends on thc_pkg, thc_log_cell and thc_div_cell.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------
//   in       | in_valid / in_ready | adc_code
//   out      | out_valid/out_ready | temp_c, valid_res
//   cfg      | cfg_we              | cfg_index, cfg_data
//
// One transfer in per cycle while the output is not stalled; the pipe is 30 log cells,
// 9 divider cells and the arithmetic stages around them.
// Reset clears the stage valid bits and loads the default coefficients.
// The whole pipe holds while a result waits and out_ready is low.
module thermistor_adc_to_celsius_top
    import thc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ADC_BITS-1:0]      adc_code,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [TEMP_W-1:0] temp_c,
    output logic                     valid_res,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int NST  = 2 + LOG_FRAC + 6 + 1 + Q_W + 1;
    localparam int L_W  = 30;
    localparam int L2_W = 26;

    logic [COEF_W-1:0] coef_a_reg;
    logic [COEF_W-1:0] coef_b_reg;
    logic [COEF_W-1:0] coef_c_reg;
    logic [SER_W-1:0]  series_reg;
    logic [NST-1:0]    vld_reg;
    logic              adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= COEF_A_RST;
            coef_b_reg <= COEF_B_RST;
            coef_c_reg <= COEF_C_RST;
            series_reg <= SERIES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COEF_A: coef_a_reg <= cfg_data[COEF_W-1:0];
                CFG_COEF_B: coef_b_reg <= cfg_data[COEF_W-1:0];
                CFG_COEF_C: coef_c_reg <= cfg_data[COEF_W-1:0];
                CFG_SERIES: series_reg <= cfg_data[SER_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv       = !vld_reg[NST-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    // front end: resistance ratio operands
    logic [SER_W-1:0] ser_eff;
    logic [X_W-1:0]   x1_reg;
    logic [X_W-1:0]   x2_reg;
    logic             ok0_reg;

    assign ser_eff = (series_reg == '0) ? SER_W'(1) : series_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg  <= X_W'(ser_eff * adc_code);
            x2_reg  <= X_W'(ADC_BITS'(ADC_FULL) - adc_code);
            ok0_reg <= (adc_code != '0) && (adc_code != ADC_BITS'(ADC_FULL));
        end
    end

    // normalise and run the log chain
    thc_log_t lg [LOG_FRAC+1];
    thc_log_t lg0_next;
    thc_log_t lg0_reg;
    logic [N_W-1:0] n1;
    logic [N_W-1:0] n2;

    always_comb
    begin
        n1          = msb_pos(x1_reg);
        n2          = msb_pos(x2_reg);
        lg0_next.y1 = norm_mant(x1_reg, n1);
        lg0_next.y2 = norm_mant(x2_reg, n2);
        lg0_next.r1 = R_W'(n1);
        lg0_next.r2 = R_W'(n2);
        lg0_next.ok = ok0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            lg0_reg <= lg0_next;
    end

    assign lg[0] = lg0_reg;

    for (genvar i = 0; i < LOG_FRAC; i++)
    begin : g_log
        thc_log_cell u_cell (
            .clk (clk),
            .en  (adv),
            .d   (lg[i]),
            .q   (lg[i+1])
        );
    end

    // L = (log2 num - log2 den) * ln2
    logic signed [R_W:0]  dl;
    logic signed [63:0]   p_reg;
    logic                 ok2_reg;
    logic signed [L_W-1:0] l_reg;
    logic                 ok3_reg;
    logic signed [2*L_W-1:0] lsq_reg;
    logic signed [63:0]   bl_reg;
    logic                 ok4_reg;
    logic signed [L2_W-1:0] l2_reg;
    logic signed [63:0]   blr_reg;
    logic                 ok5_reg;
    logic signed [63:0]   cl_reg;
    logic signed [63:0]   blr6_reg;
    logic                 ok6_reg;
    logic signed [S_W-1:0] s_reg;
    logic                 ok7_reg;
    logic signed [63:0]   s_sum;

    assign dl = $signed({1'b0, lg[LOG_FRAC].r1}) - $signed({1'b0, lg[LOG_FRAC].r2});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg    <= 64'(dl * $signed({1'b0, LN2_Q28}));
            ok2_reg  <= lg[LOG_FRAC].ok;
            l_reg    <= L_W'(shr_round(p_reg, 34));
            ok3_reg  <= ok2_reg;
            lsq_reg  <= l_reg * l_reg;
            bl_reg   <= 64'($signed(coef_b_reg) * l_reg);
            ok4_reg  <= ok3_reg;
            l2_reg   <= L2_W'(shr_round(64'(lsq_reg), 32));
            blr_reg  <= shr_round(bl_reg, 24);
            ok5_reg  <= ok4_reg;
            cl_reg   <= 64'($signed(coef_c_reg) * l2_reg);
            blr6_reg <= blr_reg;
            ok6_reg  <= ok5_reg;
            s_reg    <= s_sum[S_W-1:0];
            ok7_reg  <= ok6_reg;
        end
    end

    assign s_sum = 64'($signed(coef_a_reg)) + blr6_reg + shr_round(cl_reg, 16);

    // classify S and set up the division
    thc_div_t           dv [Q_W+1];
    thc_div_t           dv0_next;
    thc_div_t           dv0_reg;
    logic [DIV_W-1:0]   den;
    logic signed [DIV_W-1:0] num;
    logic [DIV_W-1:0]   mag;

    always_comb
    begin
        den = DIV_W'(s_reg) * DIV_W'(100);
        num = (DIV_W'(100) << 40) - DIV_W'(s_reg) * DIV_W'(27315);
        mag = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
        dv0_next.rem = mag;
        dv0_next.dsh = den << (Q_W - 1);
        dv0_next.q   = '0;
        dv0_next.neg = num[DIV_W-1];
        dv0_next.ovf = mag >= (den << Q_W);
        dv0_next.ok  = ok7_reg;
        if (s_reg == '0)
            dv0_next.cls = CLS_HOT;
        else if (s_reg[S_W-1] || s_reg > (S_W'(1) << 40))
            dv0_next.cls = CLS_COLD;
        else
            dv0_next.cls = CLS_NORM;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dv0_reg <= dv0_next;
    end

    assign dv[0] = dv0_reg;

    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        thc_div_cell u_cell (
            .clk (clk),
            .en  (adv),
            .d   (dv[k]),
            .q   (dv[k+1])
        );
    end

    // saturate and register the result
    thc_div_t                  dfin;
    logic signed [TEMP_W-1:0]  t_next;
    logic signed [TEMP_W-1:0]  temp_reg;
    logic                      vres_reg;

    assign dfin = dv[Q_W];

    always_comb
    begin
        case (dfin.cls)
            CLS_HOT:  t_next = TEMP_MAX;
            CLS_COLD: t_next = TEMP_MIN;
            default:
            begin
                if (dfin.ovf)
                    t_next = dfin.neg ? TEMP_MIN : TEMP_MAX;
                else if (dfin.neg)
                    t_next = (dfin.q > Q_W'(100)) ? TEMP_MIN : -$signed(TEMP_W'(dfin.q));
                else
                    t_next = (dfin.q > Q_W'(400)) ? TEMP_MAX : $signed(TEMP_W'(dfin.q));
            end
        endcase
        if (!dfin.ok)
            t_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            temp_reg <= t_next;
            vres_reg <= dfin.ok;
        end
    end

    assign temp_c    = temp_reg;
    assign valid_res = vres_reg;

`ifndef NO_ASSERTIONS
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> temp_c == '0)
        else $error("invalid code gave non-zero temperature");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> temp_c >= TEMP_MIN && temp_c <= TEMP_MAX)
        else $error("temperature outside saturation range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input held without output backpressure");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vld_reg))
        else $error("pipe advanced during stall");
`endif

endmodule

[design/thc_log_cell.sv]
// One fraction bit of two parallel log2 lanes: square, test, renormalise.
// Depends on thc_pkg.
module thc_log_cell
    import thc_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  thc_log_t d,
    output thc_log_t q
);

    logic [2*Y_W-1:0] sq1;
    logic [2*Y_W-1:0] sq2;
    logic [Y_W:0]     t1;
    logic [Y_W:0]     t2;
    thc_log_t         q_next;
    thc_log_t         q_reg;

    always_comb
    begin
        sq1 = d.y1 * d.y1;
        sq2 = d.y2 * d.y2;
        t1  = sq1[2*Y_W-1:LOG_FRAC];
        t2  = sq2[2*Y_W-1:LOG_FRAC];
        q_next    = d;
        q_next.y1 = t1[Y_W] ? t1[Y_W:1] : t1[Y_W-1:0];
        q_next.y2 = t2[Y_W] ? t2[Y_W:1] : t2[Y_W-1:0];
        q_next.r1 = {d.r1[R_W-2:0], t1[Y_W]};
        q_next.r2 = {d.r2[R_W-2:0], t2[Y_W]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

[design/thc_div_cell.sv]
// One restoring-division quotient bit with the divisor walking right.
// Depends on thc_pkg.
module thc_div_cell
    import thc_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  thc_div_t d,
    output thc_div_t q
);

    thc_div_t q_next;
    thc_div_t q_reg;
    logic     ge;

    always_comb
    begin
        ge         = d.rem >= d.dsh;
        q_next     = d;
        q_next.rem = ge ? d.rem - d.dsh : d.rem;
        q_next.dsh = d.dsh >> 1;
        q_next.q   = {d.q[Q_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

[test/thermistor_adc_to_celsius_top_test.sv]
// Testbench for thermistor_adc_to_celsius_top: converts ADC codes against a local
// fixed-point A + B*lnR + C*lnR^2 predictor with a scoreboard class. Depends on thc_pkg.
`timescale 1ns / 1ps

module thermistor_adc_to_celsius_top_test;
    import thc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LATENCY = 49;

    typedef struct {
        logic signed [TEMP_W-1:0] temp_c;
        logic                     valid_res;
    } reading_t;

    class celsius_scoreboard;
        logic [31:0] coef_a;
        logic [31:0] coef_b;
        logic [31:0] coef_c;
        logic [19:0] series_ohms;
        reading_t    pending[$];
        int          errors;
        int          checked;

        function new();
            coef_a = COEF_A_RST;
            coef_b = COEF_B_RST;
            coef_c = COEF_C_RST;
            series_ohms = SERIES_RST;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_COEF_A: coef_a = val;
                CFG_COEF_B: coef_b = val;
                CFG_COEF_C: coef_c = val;
                CFG_SERIES: series_ohms = val[19:0];
                default: ;
            endcase
        endfunction

        function longint round_shift(longint v, int s);
            longint unsigned mag;
            mag = (v < 0) ? longint'(-v) : longint'(v);
            mag = (mag + (64'd1 << (s - 1))) >> s;
            return (v < 0) ? -longint'(mag) : longint'(mag);
        endfunction

        function longint unsigned log2_fixed(longint unsigned x);
            int n;
            longint unsigned t;
            longint unsigned y;
            longint unsigned r;
            n = 0;
            t = x;
            while (t > 1) begin
                t = t >> 1;
                n++;
            end
            y = (n >= LOG_FRAC) ? (x >> (n - LOG_FRAC)) : (x << (LOG_FRAC - n));
            r = longint'(n) << LOG_FRAC;
            for (int i = LOG_FRAC - 1; i >= 0; i--) begin
                y = (y * y) >> LOG_FRAC;
                if (y >= (64'd2 << LOG_FRAC)) begin
                    y = y >> 1;
                    r = r | (64'd1 << i);
                end
            end
            return r;
        endfunction

        function reading_t convert(logic [ADC_BITS-1:0] code);
            reading_t res;
            longint unsigned ser;
            longint d;
            longint lnr;
            longint lnr2;
            longint s;
            longint t;
            res.temp_c = '0;
            res.valid_res = 1'b0;
            if (code == 0 || code == ADC_FULL)
                return res;
            ser = (series_ohms == 0) ? 1 : series_ohms;
            d = longint'(log2_fixed(ser * code)) - longint'(log2_fixed(ADC_FULL - code));
            lnr = round_shift(d * longint'(LN2_Q28), 34);
            lnr2 = round_shift(lnr * lnr, 32);
            s = longint'($signed(coef_a)) + round_shift(longint'($signed(coef_b)) * lnr, 24)
                + round_shift(longint'($signed(coef_c)) * lnr2, 16);
            if (s == 0)
                t = 400;
            else if (s < 0 || s > (64'sd1 <<< 40))
                t = -100;
            else begin
                t = (64'sd100 * (64'sd1 <<< 40) - 64'sd27315 * s) / (64'sd100 * s);
                if (t > 400)
                    t = 400;
                if (t < -100)
                    t = -100;
            end
            res.temp_c = t[TEMP_W-1:0];
            res.valid_res = 1'b1;
            return res;
        endfunction

        function void note_code(logic [ADC_BITS-1:0] code);
            pending.push_back(convert(code));
        endfunction

        function void check_reading(logic signed [TEMP_W-1:0] temp, logic vres);
            reading_t exp_r;
            checked++;
            if (pending.size() == 0) begin
                $error("unexpected result temp_c=%0d valid_res=%0b", temp, vres);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (temp !== exp_r.temp_c) begin
                $error("temp_c expected %0d actual %0d", exp_r.temp_c, temp);
                errors++;
            end
            if (vres !== exp_r.valid_res) begin
                $error("valid_res expected %0b actual %0b", exp_r.valid_res, vres);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [ADC_BITS-1:0]      adc_code;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [TEMP_W-1:0] temp_c;
    logic                     valid_res;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    celsius_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles;
    int  codes_sent;
    int  settings_run;

    thermistor_adc_to_celsius_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .adc_code  (adc_code),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .temp_c    (temp_c),
        .valid_res (valid_res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // drain results and count stalled cycles
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                board.check_reading(temp_c, valid_res);
            if ((out_valid && out_ready) || (in_valid && in_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_code(logic [ADC_BITS-1:0] code);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        adc_code <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_code(code);
        codes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        board.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic set_config(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                              logic [31:0] ser);
        wait_drained();
        write_reg(CFG_COEF_A, a);
        write_reg(CFG_COEF_B, b);
        write_reg(CFG_COEF_C, c);
        write_reg(CFG_SERIES, ser);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    task automatic random_codes(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(19);
            if (pick == 0)
                send_code(0);
            else if (pick == 1)
                send_code(ADC_BITS'(ADC_FULL));
            else if (pick < 4)
                send_code(ADC_BITS'($urandom_range(ADC_FULL)));
            else
                send_code(ADC_BITS'($urandom_range(ADC_FULL - 1, 1)));
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        adc_code = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet_cycles = 0;
        codes_sent = 0;
        settings_run = 0;
        send_idle_pct = 38;
        recv_idle_pct = 50;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset coefficients, code extremes and every bit
        send_code(0);
        send_code(ADC_BITS'(ADC_FULL));
        send_code(1);
        send_code(ADC_BITS'(ADC_FULL - 1));
        send_code(512);
        send_code(511);
        for (int b = 0; b < ADC_BITS; b++)
            send_code(10'd1 << b);
        send_code(10'h2AA);
        send_code(10'h155);
        // zero denominator, negative denominator, sub-kelvin, zero series resistor
        set_config(32'd0, 32'd0, 32'd0, 32'd0);
        send_code(300);
        set_config(32'h8000_0000, 32'd0, 32'd0, 32'd1);
        send_code(700);
        set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1000000);
        send_code(900);
        send_code(5);
        set_config(32'd0, 32'h8000_0000, 32'h8000_0000, 32'hFFFFF);
        send_code(100);
        send_code(1000);

        set_config(COEF_A_RST, COEF_B_RST, COEF_C_RST, 32'(SERIES_RST));
        random_codes(450);
        // hold off until the pipe is empty
        wait_drained();
        send_idle_pct = 50;
        recv_idle_pct = 38;
        set_config($urandom, $urandom, $urandom, $urandom_range(1000000, 1));
        random_codes(150);
        set_config(COEF_A_RST + $urandom_range(4000000), COEF_B_RST, COEF_C_RST,
                   $urandom_range(1000000, 1));
        random_codes(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config($urandom, $urandom, $urandom, $urandom);
        random_codes(150);
        set_config(COEF_A_RST, COEF_B_RST, COEF_C_RST, 32'(SERIES_RST));
        random_codes(475);

        wait_drained();
        $display("Converted %0d codes across %0d coefficient sets, %0d results checked.",
                 codes_sent, settings_run, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
